// ----- sv/fmqd_pkg.sv -----
// ----------------------------------------------------------------------------
// fmqd_pkg - FM quadrature discriminator shared definitions
// Widths, fixed-point constants, the arctangent table and state types.
// ----------------------------------------------------------------------------
`default_nettype none

package fmqd_pkg;

    // Sample and iteration settings
    localparam int SAMPLE_WIDTH      = 16;
    localparam int CORDIC_ITERATIONS = 16;
    localparam int ITER_W            = $clog2(CORDIC_ITERATIONS);
    localparam int ATAN_TABLE_SIZE   = 24;
    localparam int TBL_IDX_W         = $clog2(ATAN_TABLE_SIZE);

    // Product and CORDIC widths
    localparam int PROD_W      = 2 * SAMPLE_WIDTH;
    localparam int GUARD_BITS  = 8;
    // conj product sum (+1), guard shift, CORDIC gain and pre-rotation headroom (+3)
    localparam int CORDIC_W    = PROD_W + 1 + GUARD_BITS + 3;
    // Q2.30 angle plus range for pi pre-rotation and the atan sum
    localparam int ANGLE_W     = 35;

    // Gain register, Q0.15
    localparam int GAIN_W = 15;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 15'd9830;

    // Output, Q3.13
    localparam int OUT_W   = 16;
    localparam int SCALE_W = ANGLE_W + GAIN_W + 1;
    localparam int FRAC_SHIFT = 32;
    localparam int SHIFTED_W  = SCALE_W - FRAC_SHIFT;

    localparam logic signed [SAMPLE_WIDTH-1:0] PHASE_ZERO_I =
        SAMPLE_WIDTH'((2 ** (SAMPLE_WIDTH - 1)) - 1);

    localparam logic signed [ANGLE_W-1:0] PI_Q30 = 35'sd3373259426;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_PREP,
        ST_ITER,
        ST_SCALE,
        ST_ROUND
    } state_t;

    // Order of the four partial products of conj(prev) * cur
    typedef enum logic [1:0] {
        MS_RE_A,   // prev_i * cur_i
        MS_RE_B,   // + prev_q * cur_q
        MS_IM_A,   // prev_i * cur_q
        MS_IM_B    // - prev_q * cur_i
    } mul_step_t;

    // atan(2^-k) in Q2.30, truncated; zero past the table
    function automatic logic signed [ANGLE_W-1:0] atan_q30(input logic [TBL_IDX_W-1:0] k);
        logic [31:0] a;
        case (k)
            5'd0:    a = 32'h3243F6A8;
            5'd1:    a = 32'h1DAC6705;
            5'd2:    a = 32'h0FADBAFC;
            5'd3:    a = 32'h07F56EA6;
            5'd4:    a = 32'h03FEAB76;
            5'd5:    a = 32'h01FFD55B;
            5'd6:    a = 32'h00FFFAAA;
            5'd7:    a = 32'h007FFF55;
            5'd8:    a = 32'h003FFFEA;
            5'd9:    a = 32'h001FFFFD;
            5'd10:   a = 32'h000FFFFF;
            5'd11:   a = 32'h0007FFFF;
            5'd12:   a = 32'h0003FFFF;
            5'd13:   a = 32'h0001FFFF;
            5'd14:   a = 32'h0000FFFF;
            5'd15:   a = 32'h00007FFF;
            5'd16:   a = 32'h00003FFF;
            5'd17:   a = 32'h00001FFF;
            5'd18:   a = 32'h00000FFF;
            5'd19:   a = 32'h000007FF;
            5'd20:   a = 32'h000003FF;
            5'd21:   a = 32'h000001FF;
            5'd22:   a = 32'h000000FF;
            5'd23:   a = 32'h0000007F;
            default: a = 32'h00000000;
        endcase
        return ANGLE_W'(a);
    endfunction

endpackage

`default_nettype wire

// ----- sv/fmqd_if.sv -----
// ----------------------------------------------------------------------------
// fmqd_if - FM quadrature discriminator channel interfaces
// Valid/ready channels for I/Q samples in and demodulated audio out.
// ----------------------------------------------------------------------------
`default_nettype none

interface fmqd_iq_if;
    logic                                          valid;
    logic                                          ready;
    logic signed [fmqd_pkg::SAMPLE_WIDTH-1:0]      i_sample;
    logic signed [fmqd_pkg::SAMPLE_WIDTH-1:0]      q_sample;
    logic                                          resync;

    modport source (output valid, i_sample, q_sample, resync, input ready);
    modport sink   (input valid, i_sample, q_sample, resync, output ready);
endinterface

interface fmqd_audio_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [fmqd_pkg::OUT_W-1:0]      audio_value;

    modport source (output valid, audio_value, input ready);
    modport sink   (input valid, audio_value, output ready);
endinterface

`default_nettype wire

// ----- sv/fm_quadrature_discriminator.sv -----
// ----------------------------------------------------------------------------
// fm_quadrature_discriminator - FM demodulator by atan2 of conj product
// Iterative CORDIC phase discriminator with a Q0.15 output gain.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one I/Q sample (Q1.15) per transfer, plus a resync flag that
//            makes the stored previous sample phase zero for this sample.
//   out_ch : one audio_value (Q3.13 radians times gain) per input transfer.
//   cfg    : cfg_wr_en/cfg_wr_data write output_gain (Q0.15) into gain_reg;
//            write only while idle.
// Sequence:
//   One shared 16x16 multiplier forms the four partial products in turn,
//   then one pre-rotation step, then the shared shift/add CORDIC stage runs
//   CORDIC_ITERATIONS iterations, then one gain multiply and one round step.
//   The round step loads the result into the output register (a zero
//   product skips CORDIC); in_ch.ready returns once it is loaded, so a new
//   sample is taken only when the last one is through.
//   The CORDIC iteration loop is the longest part of each sample.
// Reset: previous sample = phase zero (32767, 0), gain = 9830, no result.
// Stall: a result waits in the output register; the next sample is taken
//   and processed meanwhile, and only the round step waits for the slot.
// ----------------------------------------------------------------------------
`default_nettype none

module fm_quadrature_discriminator (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    fmqd_iq_if.sink                                 in_ch,
    fmqd_audio_if.source                            out_ch,
    input  wire logic                               cfg_wr_en,
    input  wire logic [fmqd_pkg::GAIN_W-1:0]        cfg_wr_data
);

    localparam int SW = fmqd_pkg::SAMPLE_WIDTH;
    localparam int CW = fmqd_pkg::CORDIC_W;
    localparam int AW = fmqd_pkg::ANGLE_W;

    // Control
    fmqd_pkg::state_t    state_reg, state_next;
    fmqd_pkg::mul_step_t mul_step_reg, mul_step_next;
    logic [fmqd_pkg::ITER_W-1:0] iter_reg, iter_next;
    logic out_valid_reg, out_valid_next;
    logic [fmqd_pkg::GAIN_W-1:0] gain_reg, gain_next;

    // State and datapath
    logic signed [SW-1:0] prev_i_reg, prev_i_next;
    logic signed [SW-1:0] prev_q_reg, prev_q_next;
    logic signed [SW-1:0] cur_i_reg, cur_i_next;
    logic signed [SW-1:0] cur_q_reg, cur_q_next;
    logic signed [CW-1:0] x_reg, x_next;
    logic signed [CW-1:0] y_reg, y_next;
    logic signed [AW-1:0] z_reg, z_next;
    logic signed [fmqd_pkg::SCALE_W-1:0] prod_reg, prod_next;
    logic signed [fmqd_pkg::OUT_W-1:0]   out_data_reg, out_data_next;

    // Shared multiplier and CORDIC stage
    logic signed [SW-1:0]     mul_a, mul_b;
    logic signed [fmqd_pkg::PROD_W-1:0] mul_p;
    logic signed [CW-1:0]     mul_ext;
    logic signed [CW-1:0]     xs, ys;
    logic signed [AW-1:0]     atan_k;
    logic                     y_pos;
    logic                     in_xfer;
    logic                     out_load;
    logic                     iter_last;
    logic                     prod_zero;
    logic signed [fmqd_pkg::SCALE_W-1:0]   rounded;
    logic signed [fmqd_pkg::SHIFTED_W-1:0] shifted;

    assign in_xfer   = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == fmqd_pkg::ST_IDLE);
    assign out_ch.valid       = out_valid_reg;
    assign out_ch.audio_value = out_data_reg;

    assign out_load  = (state_reg == fmqd_pkg::ST_ROUND) && (!out_valid_reg || out_ch.ready);
    assign iter_last = (iter_reg == fmqd_pkg::ITER_W'(fmqd_pkg::CORDIC_ITERATIONS - 1));
    assign prod_zero = (x_reg == '0) && (y_reg == '0);

    // Operand select for the shared multiplier
    always_comb
    begin
        case (mul_step_reg)
            fmqd_pkg::MS_RE_A: begin mul_a = prev_i_reg; mul_b = cur_i_reg; end
            fmqd_pkg::MS_RE_B: begin mul_a = prev_q_reg; mul_b = cur_q_reg; end
            fmqd_pkg::MS_IM_A: begin mul_a = prev_i_reg; mul_b = cur_q_reg; end
            fmqd_pkg::MS_IM_B: begin mul_a = prev_q_reg; mul_b = cur_i_reg; end
            default:           begin mul_a = prev_i_reg; mul_b = cur_i_reg; end
        endcase
    end

    assign mul_p   = mul_a * mul_b;
    assign mul_ext = {{(CW - fmqd_pkg::PROD_W){mul_p[fmqd_pkg::PROD_W-1]}}, mul_p}
                     <<< fmqd_pkg::GUARD_BITS;

    // CORDIC stage: arithmetic shifts floor
    assign xs     = x_reg >>> iter_reg;
    assign ys     = y_reg >>> iter_reg;
    assign atan_k = fmqd_pkg::atan_q30(fmqd_pkg::TBL_IDX_W'(iter_reg));
    assign y_pos  = !y_reg[CW-1] && (y_reg != '0);

    // Round half up to Q3.13
    assign rounded = prod_reg + fmqd_pkg::SCALE_W'(64'sd1 <<< (fmqd_pkg::FRAC_SHIFT - 1));
    assign shifted = rounded[fmqd_pkg::SCALE_W-1:fmqd_pkg::FRAC_SHIFT];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fmqd_pkg::ST_IDLE:
                if (in_xfer)
                    state_next = fmqd_pkg::ST_MUL;
            fmqd_pkg::ST_MUL:
                if (mul_step_reg == fmqd_pkg::MS_IM_B)
                    state_next = fmqd_pkg::ST_PREP;
            fmqd_pkg::ST_PREP:
                state_next = prod_zero ? fmqd_pkg::ST_SCALE : fmqd_pkg::ST_ITER;
            fmqd_pkg::ST_ITER:
                if (iter_last)
                    state_next = fmqd_pkg::ST_SCALE;
            fmqd_pkg::ST_SCALE:
                state_next = fmqd_pkg::ST_ROUND;
            fmqd_pkg::ST_ROUND:
                if (out_load)
                    state_next = fmqd_pkg::ST_IDLE;
            default:
                state_next = fmqd_pkg::ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        mul_step_next  = mul_step_reg;
        iter_next      = iter_reg;
        gain_next      = cfg_wr_en ? cfg_wr_data : gain_reg;
        prev_i_next    = prev_i_reg;
        prev_q_next    = prev_q_reg;
        cur_i_next     = cur_i_reg;
        cur_q_next     = cur_q_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        z_next         = z_reg;
        prod_next      = prod_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;

        case (state_reg)
            fmqd_pkg::ST_IDLE:
                if (in_xfer)
                begin
                    cur_i_next    = in_ch.i_sample;
                    cur_q_next    = in_ch.q_sample;
                    mul_step_next = fmqd_pkg::MS_RE_A;
                    if (in_ch.resync)
                    begin
                        prev_i_next = fmqd_pkg::PHASE_ZERO_I;
                        prev_q_next = '0;
                    end
                end
            fmqd_pkg::ST_MUL:
            begin
                case (mul_step_reg)
                    fmqd_pkg::MS_RE_A: x_next = mul_ext;
                    fmqd_pkg::MS_RE_B: x_next = x_reg + mul_ext;
                    fmqd_pkg::MS_IM_A: y_next = mul_ext;
                    fmqd_pkg::MS_IM_B:
                    begin
                        y_next      = y_reg - mul_ext;
                        prev_i_next = cur_i_reg;
                        prev_q_next = cur_q_reg;
                    end
                    default: x_next = mul_ext;
                endcase
                mul_step_next = fmqd_pkg::mul_step_t'(mul_step_reg + 2'd1);
            end
            fmqd_pkg::ST_PREP:
            begin
                iter_next = '0;
                z_next    = '0;
                // Left half plane: turn by pi toward the right half plane
                if (!prod_zero && x_reg[CW-1])
                begin
                    z_next = y_reg[CW-1] ? -fmqd_pkg::PI_Q30 : fmqd_pkg::PI_Q30;
                    x_next = -x_reg;
                    y_next = -y_reg;
                end
            end
            fmqd_pkg::ST_ITER:
            begin
                if (y_pos)
                begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + atan_k;
                end
                else
                begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - atan_k;
                end
                iter_next = iter_reg + 1'b1;
            end
            fmqd_pkg::ST_SCALE:
                prod_next = z_reg * $signed({1'b0, gain_reg});
            fmqd_pkg::ST_ROUND:
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    if (!shifted[fmqd_pkg::SHIFTED_W-1]
                        && (shifted[fmqd_pkg::SHIFTED_W-2:fmqd_pkg::OUT_W-1] != '0))
                        out_data_next = {1'b0, {(fmqd_pkg::OUT_W-1){1'b1}}};
                    else if (shifted[fmqd_pkg::SHIFTED_W-1]
                        && (shifted[fmqd_pkg::SHIFTED_W-2:fmqd_pkg::OUT_W-1] != '1))
                        out_data_next = {1'b1, {(fmqd_pkg::OUT_W-1){1'b0}}};
                    else
                        out_data_next = shifted[fmqd_pkg::OUT_W-1:0];
                end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fmqd_pkg::ST_IDLE;
            mul_step_reg  <= fmqd_pkg::MS_RE_A;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
            gain_reg      <= fmqd_pkg::GAIN_RESET;
            prev_i_reg    <= fmqd_pkg::PHASE_ZERO_I;
            prev_q_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            mul_step_reg  <= mul_step_next;
            iter_reg      <= iter_next;
            out_valid_reg <= out_valid_next;
            gain_reg      <= gain_next;
            prev_i_reg    <= prev_i_next;
            prev_q_reg    <= prev_q_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_i_reg    <= cur_i_next;
        cur_q_reg    <= cur_q_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        z_reg        <= z_next;
        prod_reg     <= prod_next;
        out_data_reg <= out_data_next;
    end

    // Assertions
    a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !in_ch.ready)
        else $error("input ready while a sample is in progress");

    a_resync_phase_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && in_ch.resync) |=>
        (prev_i_reg == fmqd_pkg::PHASE_ZERO_I) && (prev_q_reg == '0))
        else $error("resync did not restore phase zero");

    a_zero_product: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fmqd_pkg::ST_PREP && prod_zero) |=>
        (z_reg == '0) && (state_reg == fmqd_pkg::ST_SCALE))
        else $error("zero product did not give a zero angle");

    a_iter_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fmqd_pkg::ST_ITER && iter_last) |=> (state_reg == fmqd_pkg::ST_SCALE))
        else $error("CORDIC did not end after the last iteration");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid_reg)
        else $error("round step finished without a result");

endmodule

`default_nettype wire

// ----- tb/fm_quadrature_discriminator_tb.sv -----
// ----------------------------------------------------------------------------
// fm_quadrature_discriminator_tb - self-checking bench for the FM discriminator
// Sends I/Q samples over the valid/ready input channel and checks every audio
// transfer against a pinned value or an in-bench bit-true model of the CORDIC
// conj-product angle, Q0.15 gain and rounding, over several gain settings.
// ----------------------------------------------------------------------------
module fm_quadrature_discriminator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [fmqd_pkg::SAMPLE_WIDTH-1:0] sample_t;
    typedef logic signed [fmqd_pkg::OUT_W-1:0]        audio_t;
    typedef logic [fmqd_pkg::GAIN_W-1:0]              gain_t;

    // One directed stimulus row. pinned marks a row whose audio value is
    // known by inspection; the rest are checked against the model below.
    typedef struct packed {
        sample_t i_val;
        sample_t q_val;
        logic    resync;
        logic    pinned;
        audio_t  audio;
    } probe_row_t;

    localparam sample_t S_MAX = 16'sh7FFF;
    localparam sample_t S_MIN = 16'sh8000;
    localparam gain_t   GAIN_AT_RESET = 15'd9830;

    localparam int  CLK_HALF       = 4;
    localparam int  RESET_CYCLES   = 7;
    localparam int  ITEMS_PER_GAIN = 225;
    localparam int  GAIN_SETTINGS  = 6;
    localparam int  TAIL_CYCLES    = 40;
    localparam int  CYCLE_LIMIT    = 600_000;

    // Vectoring CORDIC constants, Q2.30
    localparam int     ROTATIONS  = fmqd_pkg::CORDIC_ITERATIONS;
    localparam int     GUARD_SH   = 8;
    localparam longint PI_Q30_L   = 64'sd3373259426;
    localparam longint ATAN_STEP [0:23] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
        64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
        64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
    };

    logic  clk;
    logic  rst_n;
    logic  cfg_wr_en;
    gain_t cfg_wr_data;

    fmqd_iq_if    iq_ch();
    fmqd_audio_if audio_ch();

    fm_quadrature_discriminator dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (iq_ch),
        .out_ch      (audio_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // ------------------------------------------------------------------
    // Model state: previous sample and the gain shadow
    // ------------------------------------------------------------------
    sample_t last_i  = S_MAX;     // phase zero after reset
    sample_t last_q  = 16'sd0;
    gain_t   gain_sh = GAIN_AT_RESET;

    audio_t  audio_expected_q [$];
    int      mismatch_count = 0;
    int      cycle_count    = 0;

    // Idle percentages for the two sides, changed per test phase
    int      src_idle_pct = 0;
    int      snk_idle_pct = 0;

    // Sideband for the directed table: pinned value of the row on the bus
    logic    row_pinned = 1'b0;
    audio_t  row_audio  = '0;

    // Directed rows, run at the reset gain
    probe_row_t probe_rows [0:15] = '{
        // zero product: current sample is the origin
        '{16'sd0,      16'sd0,      1'b0, 1'b1, 16'sd0},
        // previous sample is the origin, product is zero again
        '{16'sd12345,  -16'sd777,   1'b0, 1'b1, 16'sd0},
        // resync back to phase zero, full-scale positive real
        '{S_MAX,       16'sd0,      1'b1, 1'b0, 16'sd0},
        // negative real axis: turns into +pi
        '{S_MIN,       16'sd0,      1'b0, 1'b0, 16'sd0},
        '{S_MIN,       S_MIN,       1'b0, 1'b0, 16'sd0},
        '{S_MAX,       S_MAX,       1'b0, 1'b0, 16'sd0},
        '{S_MIN,       S_MAX,       1'b0, 1'b0, 16'sd0},
        '{S_MAX,       S_MIN,       1'b0, 1'b0, 16'sd0},
        // quarter turns against phase zero
        '{16'sd0,      S_MAX,       1'b1, 1'b0, 16'sd0},
        '{16'sd0,      S_MIN,       1'b1, 1'b0, 16'sd0},
        // resync then negative real axis
        '{S_MIN,       16'sd0,      1'b1, 1'b0, 16'sd0},
        // tiny products, resolved by the CORDIC
        '{16'sd1,      16'sd0,      1'b0, 1'b0, 16'sd0},
        '{16'sd0,      16'sd1,      1'b0, 1'b0, 16'sd0},
        '{-16'sd1,     -16'sd1,     1'b0, 1'b0, 16'sd0},
        // resync with the origin: still a zero product
        '{16'sd0,      16'sd0,      1'b1, 1'b1, 16'sd0},
        '{-16'sd1,     16'sd0,      1'b0, 1'b1, 16'sd0}
    };

    // ------------------------------------------------------------------
    // Model: angle of (re, im) in Q2.30 by vectoring CORDIC
    // ------------------------------------------------------------------
    function automatic longint vector_angle(input longint re, input longint im);
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        longint step_angle;
        int     k;
        x = re <<< GUARD_SH;
        y = im <<< GUARD_SH;
        z = 0;
        // left half plane: rotate by pi first
        if (x < 0)
        begin
            z = (y >= 0) ? PI_Q30_L : -PI_Q30_L;
            x = -x;
            y = -y;
        end
        for (k = 0; k < ROTATIONS; k++)
        begin
            step_angle = (k < 24) ? ATAN_STEP[k] : 64'sd0;
            xs = x >>> k;
            ys = y >>> k;
            if (y > 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + step_angle;
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - step_angle;
            end
        end
        return z;
    endfunction

    // Model: one sample in, one scaled phase step out; advances the history
    function automatic audio_t demod_step(input sample_t cur_i, input sample_t cur_q,
                                          input logic resync);
        longint pi_l;
        longint pq_l;
        longint ci_l;
        longint cq_l;
        longint re;
        longint im;
        longint angle;
        longint scaled;
        if (resync)
        begin
            last_i = S_MAX;
            last_q = 16'sd0;
        end
        pi_l = longint'(last_i);
        pq_l = longint'(last_q);
        ci_l = longint'(cur_i);
        cq_l = longint'(cur_q);
        // conj(prev) * cur
        re = pi_l * ci_l + pq_l * cq_l;
        im = pi_l * cq_l - pq_l * ci_l;
        angle = (re == 0 && im == 0) ? 64'sd0 : vector_angle(re, im);
        // Q2.30 * Q0.15, round half up to Q3.13
        scaled = (angle * longint'(gain_sh) + (64'sd1 <<< 31)) >>> 32;
        if (scaled > 32767)
            scaled = 32767;
        if (scaled < -32768)
            scaled = -32768;
        last_i = cur_i;
        last_q = cur_q;
        return audio_t'(scaled);
    endfunction

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    // Audio sink back-pressure, redrawn every cycle at the falling edge
    always @(negedge clk)
    begin
        audio_ch.ready = ($urandom_range(0, 99) >= snk_idle_pct);
    end

    // ------------------------------------------------------------------
    // Monitor: gain writes, input transfers -> model, output transfers -> check
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        audio_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else if (rst_n)
        begin
            if (cfg_wr_en)
                gain_sh = cfg_wr_data;
            if (iq_ch.valid && iq_ch.ready)
            begin
                // model runs on every row so the history stays in step
                want = demod_step(iq_ch.i_sample, iq_ch.q_sample, iq_ch.resync);
                if (row_pinned)
                    want = row_audio;
                audio_expected_q = {audio_expected_q, want};
            end
            if (audio_ch.valid && audio_ch.ready)
            begin
                if (audio_expected_q.size() == 0)
                begin
                    $error("audio_value: no transfer expected, actual %0d",
                           audio_ch.audio_value);
                    mismatch_count++;
                end
                else
                begin
                    want = audio_expected_q.pop_front();
                    if (audio_ch.audio_value !== want)
                    begin
                        $error("audio_value: expected %0d, actual %0d",
                               want, audio_ch.audio_value);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver tasks (all input changes at the falling edge)
    // ------------------------------------------------------------------

    // One input transfer, with random idle cycles in front of it
    task automatic send_sample(input sample_t i_val, input sample_t q_val, input logic rs,
                               input logic pinned, input audio_t audio);
        @(negedge clk);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            iq_ch.valid = 1'b0;
            @(negedge clk);
        end
        iq_ch.valid    = 1'b1;
        iq_ch.i_sample = i_val;
        iq_ch.q_sample = q_val;
        iq_ch.resync   = rs;
        row_pinned     = pinned;
        row_audio      = audio;
        do
            @(posedge clk);
        while (!iq_ch.ready);
    endtask

    // Stop sending and wait until every expected audio transfer is seen
    task automatic drain_audio();
        @(negedge clk);
        iq_ch.valid = 1'b0;
        row_pinned  = 1'b0;
        while (audio_expected_q.size() != 0)
            @(negedge clk);
    endtask

    // Single-cycle gain write; only called with the block idle
    task automatic write_gain(input gain_t g);
        @(negedge clk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = g;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
    endtask

    function automatic sample_t neg_sat(input sample_t v);
        return (v == S_MIN) ? S_MAX : -v;
    endfunction

    function automatic sample_t pick_corner();
        case ($urandom_range(0, 4))
            0:       return S_MIN;
            1:       return -16'sd1;
            2:       return 16'sd0;
            3:       return 16'sd1;
            default: return S_MAX;
        endcase
    endfunction

    function automatic sample_t nudge(input sample_t v);
        int t;
        t = int'(v) + int'($urandom_range(0, 4000)) - 2000;
        if (t > 32767)
            t = 32767;
        if (t < -32768)
            t = -32768;
        return sample_t'(t);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        gain_t   gain_plan [GAIN_SETTINGS];
        sample_t si;
        sample_t sq;
        sample_t hist_i;
        sample_t hist_q;
        logic    rs;
        int      ph;
        int      n;

        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        iq_ch.valid    = 1'b0;
        iq_ch.i_sample = '0;
        iq_ch.q_sample = '0;
        iq_ch.resync   = 1'b0;
        audio_ch.ready = 1'b0;

        // radio, both extremes, smallest nonzero, a random one, back to TV
        gain_plan[0] = 15'd26214;
        gain_plan[1] = 15'd0;
        gain_plan[2] = 15'h7FFF;
        gain_plan[3] = 15'd1;
        gain_plan[4] = gain_t'($urandom_range(0, 32767));
        gain_plan[5] = GAIN_AT_RESET;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed rows at the reset gain; sender idles 33%, receiver 66%
        src_idle_pct = 33;
        snk_idle_pct = 66;
        foreach (probe_rows[r])
            send_sample(probe_rows[r].i_val, probe_rows[r].q_val, probe_rows[r].resync,
                        probe_rows[r].pinned, probe_rows[r].audio);
        hist_i = probe_rows[15].i_val;
        hist_q = probe_rows[15].q_val;

        for (ph = 0; ph < GAIN_SETTINGS; ph++)
        begin
            drain_audio();
            write_gain(gain_plan[ph]);
            // two phases per idle pattern: receiver-heavy gaps, flipped, then none
            case (ph / 2)
                0:
                begin
                    src_idle_pct = 33;
                    snk_idle_pct = 66;
                end
                1:
                begin
                    src_idle_pct = 66;
                    snk_idle_pct = 33;
                end
                default:
                begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end
            endcase
            for (n = 0; n < ITEMS_PER_GAIN; n++)
            begin
                // mostly full-range samples; also small ones, corners,
                // slow phase drift and exact opposites (negative real axis)
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4:
                    begin
                        si = sample_t'($urandom);
                        sq = sample_t'($urandom);
                    end
                    5, 6:
                    begin
                        si = sample_t'(int'($urandom_range(0, 30)) - 15);
                        sq = sample_t'(int'($urandom_range(0, 30)) - 15);
                    end
                    7:
                    begin
                        si = pick_corner();
                        sq = pick_corner();
                    end
                    8:
                    begin
                        si = nudge(hist_i);
                        sq = nudge(hist_q);
                    end
                    default:
                    begin
                        si = neg_sat(hist_i);
                        sq = neg_sat(hist_q);
                    end
                endcase
                rs = ($urandom_range(0, 15) == 0);
                send_sample(si, sq, rs, 1'b0, '0);
                hist_i = si;
                hist_q = sq;
                // now and then hold off until the pipe is empty
                if ($urandom_range(0, 49) == 0)
                    drain_audio();
            end
        end

        drain_audio();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (audio_expected_q.size() != 0)
        begin
            $error("audio_value: %0d expected transfers never arrived",
                   audio_expected_q.size());
            mismatch_count++;
        end

        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
